@@ src/pptt_pkg.sv @@
// ----------------------------------------------------------------------------
// pptt_pkg
// Shared codes and types of the pending packet timeout table.
// ----------------------------------------------------------------------------
package pptt_pkg;

    // Operation codes carried on kind
    localparam logic [2:0] KIND_ALLOC   = 3'd0;
    localparam logic [2:0] KIND_FILL    = 3'd1;
    localparam logic [2:0] KIND_RELEASE = 3'd2;
    localparam logic [2:0] KIND_QUERY   = 3'd3;
    localparam logic [2:0] KIND_TICK    = 3'd4;
    localparam logic [2:0] KIND_FLUSH   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10;
    localparam logic [15:0] RETRY_MAX     = 16'hFFFF;

    // One slot of the main table; retry counts live in a memory of their own
    typedef struct packed {
        logic        busy;
        logic [31:0] stamp;
        logic [15:0] kind;
        logic [15:0] size;
    } slot_t;

    // Access to the slot memories for one cycle
    typedef struct packed {
        logic [15:0] rd_addr;
        logic        wr_slot;
        logic        wr_retry;
        logic [15:0] wr_addr;
        slot_t       slot_data;
        logic [15:0] retry_data;
    } ram_cmd_t;

endpackage

@@ src/pptt_slot_ram.sv @@
// ----------------------------------------------------------------------------
// pptt_slot_ram
// Slot and retry memories: one write port each, shared registered read.
// ----------------------------------------------------------------------------
module pptt_slot_ram import pptt_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic     clk,
    input  ram_cmd_t cmd,
    output slot_t    slot_q,
    output logic [15:0] retry_q
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    slot_t       slot_mem  [ENTRIES];
    logic [15:0] retry_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_slot)
        begin
            slot_mem[cmd.wr_addr[IW-1:0]] <= cmd.slot_data;
        end
        if (cmd.wr_retry)
        begin
            retry_mem[cmd.wr_addr[IW-1:0]] <= cmd.retry_data;
        end
        slot_q  <= slot_mem[cmd.rd_addr[IW-1:0]];
        retry_q <= retry_mem[cmd.rd_addr[IW-1:0]];
    end

endmodule

@@ src/pending_packet_timeout_table_top.sv @@
// ----------------------------------------------------------------------------
// pending_packet_timeout_table_top
// Table of pending packets with allocate, fill, release, query, tick, flush.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken on a rising edge with start high and busy low.
//   Every command gives one result word on the result ports, marked by done
//   for one cycle, except a tick that finds expired slots: it gives one word
//   per expired slot, in slot order, the final one flagged by last.
//   The receiver cannot stall; results are never held back.
//   Progress, with the slot memories read through a register:
//     fill, release, query : one access to the addressed slot
//     allocate             : one slot probed per cycle
//     tick                 : one slot aged per cycle;
//                            an empty table answers without a pass
//     flush                : one slot wiped per cycle
//     unknown kind         : answered from idle with status bad
//   After reset a clearing pass zeroes both memories; busy
//   stays high meanwhile. The timeout register (cfg_wr_en / cfg_wr_data)
//   resets to 10 and may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module pending_packet_timeout_table_top import pptt_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [15:0] entry_index,
    input  logic [15:0] pdu_type,
    input  logic [15:0] length,
    input  logic [31:0] now,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] slot_index,
    output logic [15:0] slot_type,
    output logic [15:0] slot_length,
    output logic [15:0] retry_count,
    output logic        timed_out,
    output logic        last
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] FIRST_SLOT = IW'(1);
    localparam logic [IW-1:0] LAST_SLOT  = IW'(ENTRIES - 1);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_ALLOC    = 3'd2;
    localparam logic [2:0] S_SLOT     = 3'd3;
    localparam logic [2:0] S_TICK     = 3'd4;
    localparam logic [2:0] S_TICK_END = 3'd5;
    localparam logic [2:0] S_FLUSH    = 3'd6;

    // control
    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] insert_ptr_reg, insert_ptr_next;
    logic [IW-1:0] filled_reg, filled_next;
    logic [15:0]   timeout_reg;
    logic          done_reg, done_next;
    logic          held_valid_reg, held_valid_next;

    // latched command word
    logic [2:0]  kind_reg, kind_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] now_reg, now_next;
    logic        in_range_reg, in_range_next;

    // result word
    logic [1:0]  status_reg, status_next;
    logic [15:0] slot_index_reg, slot_index_next;
    logic [15:0] slot_type_reg, slot_type_next;
    logic [15:0] slot_length_reg, slot_length_next;
    logic [15:0] retry_reg, retry_next;
    logic        timed_out_reg, timed_out_next;
    logic        last_reg, last_next;

    // expired slot held back until it is known whether another follows
    logic [IW-1:0] held_idx_reg, held_idx_next;
    logic [15:0]   held_type_reg, held_type_next;
    logic [15:0]   held_len_reg, held_len_next;
    logic [15:0]   held_retry_reg, held_retry_next;

    ram_cmd_t    ram_cmd;
    slot_t       slot_q;
    logic [15:0] retry_q;

    logic [IW-1:0] cur_adv;
    logic [31:0]   age;
    logic          expired;
    logic          good;
    logic [15:0]   retry_inc;

    pptt_slot_ram #(
        .ENTRIES (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .cmd     (ram_cmd),
        .slot_q  (slot_q),
        .retry_q (retry_q)
    );

    assign cur_adv   = (cur_reg == LAST_SLOT) ? FIRST_SLOT : cur_reg + FIRST_SLOT;
    assign age       = now_reg - slot_q.stamp;
    assign expired   = slot_q.busy && (age > {16'd0, timeout_reg});
    assign good      = in_range_reg && slot_q.busy;
    assign retry_inc = (retry_q == RETRY_MAX) ? retry_q : retry_q + 16'd1;

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        cnt_next         = cnt_reg;
        insert_ptr_next  = insert_ptr_reg;
        filled_next      = filled_reg;
        done_next        = 1'b0;
        held_valid_next  = held_valid_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        type_next        = type_reg;
        len_next         = len_reg;
        now_next         = now_reg;
        in_range_next    = in_range_reg;
        status_next      = status_reg;
        slot_index_next  = slot_index_reg;
        slot_type_next   = slot_type_reg;
        slot_length_next = slot_length_reg;
        retry_next       = retry_reg;
        timed_out_next   = timed_out_reg;
        last_next        = last_reg;
        held_idx_next    = held_idx_reg;
        held_type_next   = held_type_reg;
        held_len_next    = held_len_reg;
        held_retry_next  = held_retry_reg;

        ram_cmd            = '0;
        ram_cmd.rd_addr    = 16'(cur_reg);
        ram_cmd.wr_addr    = 16'(cur_reg);

        case (state_reg)
            S_CLEAR:
            begin
                ram_cmd.wr_slot  = 1'b1;
                ram_cmd.wr_retry = 1'b1;
                cur_next         = cur_reg + FIRST_SLOT;
                if (cur_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                ram_cmd.rd_addr = entry_index;
                if (start)
                begin
                    kind_next     = kind;
                    idx_next      = entry_index;
                    type_next     = pdu_type;
                    len_next      = length;
                    now_next      = now;
                    in_range_next = (entry_index != 16'd0) &&
                                    (entry_index < 16'(ENTRIES));
                    // default result word, adjusted per command
                    status_next      = ST_OK;
                    slot_index_next  = 16'd0;
                    slot_type_next   = 16'd0;
                    slot_length_next = 16'd0;
                    retry_next       = 16'd0;
                    timed_out_next   = 1'b0;
                    last_next        = 1'b1;
                    case (kind)
                        KIND_ALLOC:
                        begin
                            ram_cmd.rd_addr = 16'(insert_ptr_reg);
                            cur_next        = insert_ptr_reg;
                            cnt_next        = '0;
                            state_next      = S_ALLOC;
                        end
                        KIND_FILL, KIND_RELEASE, KIND_QUERY:
                        begin
                            state_next = S_SLOT;
                        end
                        KIND_TICK:
                        begin
                            ram_cmd.rd_addr = 16'(FIRST_SLOT);
                            cur_next        = FIRST_SLOT;
                            held_valid_next = 1'b0;
                            if (filled_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_TICK;
                            end
                        end
                        KIND_FLUSH:
                        begin
                            cur_next   = FIRST_SLOT;
                            state_next = S_FLUSH;
                        end
                        default:
                        begin
                            status_next = ST_BAD;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                ram_cmd.rd_addr = 16'(cur_adv);
                if (!slot_q.busy)
                begin
                    ram_cmd.wr_slot         = 1'b1;
                    ram_cmd.slot_data.busy  = 1'b1;
                    ram_cmd.slot_data.stamp = now_reg;
                    insert_ptr_next         = cur_reg;
                    slot_index_next         = 16'(cur_reg);
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                end
                else if (cnt_reg == LAST_SLOT - FIRST_SLOT)
                begin
                    status_next = ST_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cur_next = cur_adv;
                    cnt_next = cnt_reg + FIRST_SLOT;
                end
            end

            S_SLOT:
            begin
                ram_cmd.wr_addr = idx_reg;
                done_next       = 1'b1;
                state_next      = S_IDLE;
                if (!good)
                begin
                    status_next = ST_BAD;
                end
                else
                begin
                    case (kind_reg)
                        KIND_FILL:
                        begin
                            ram_cmd.wr_slot    = 1'b1;
                            ram_cmd.wr_retry   = 1'b1;
                            ram_cmd.slot_data  = '{busy: 1'b1, stamp: now_reg,
                                                   kind: type_reg, size: len_reg};
                            if (filled_reg != LAST_SLOT)
                            begin
                                filled_next = filled_reg + FIRST_SLOT;
                            end
                        end
                        KIND_RELEASE:
                        begin
                            // retry count is kept
                            ram_cmd.wr_slot = 1'b1;
                            if (filled_reg != '0)
                            begin
                                filled_next = filled_reg - FIRST_SLOT;
                            end
                            if (insert_ptr_reg > idx_reg[IW-1:0])
                            begin
                                insert_ptr_next = idx_reg[IW-1:0];
                            end
                        end
                        KIND_QUERY:
                        begin
                            slot_index_next  = idx_reg;
                            slot_type_next   = slot_q.kind;
                            slot_length_next = slot_q.size;
                            retry_next       = retry_q;
                        end
                        default:
                        begin
                            status_next = ST_BAD;
                        end
                    endcase
                end
            end

            S_TICK:
            begin
                ram_cmd.rd_addr = 16'(cur_reg) + 16'd1;
                if (expired)
                begin
                    ram_cmd.wr_slot         = 1'b1;
                    ram_cmd.wr_retry        = 1'b1;
                    ram_cmd.slot_data       = slot_q;
                    ram_cmd.slot_data.stamp = now_reg;
                    ram_cmd.retry_data      = retry_inc;
                    // an earlier expiry is now known not to be the final word
                    if (held_valid_reg)
                    begin
                        done_next        = 1'b1;
                        status_next      = ST_OK;
                        slot_index_next  = 16'(held_idx_reg);
                        slot_type_next   = held_type_reg;
                        slot_length_next = held_len_reg;
                        retry_next       = held_retry_reg;
                        timed_out_next   = 1'b1;
                        last_next        = 1'b0;
                    end
                    held_valid_next = 1'b1;
                    held_idx_next   = cur_reg;
                    held_type_next  = slot_q.kind;
                    held_len_next   = slot_q.size;
                    held_retry_next = retry_inc;
                end
                if (cur_reg == LAST_SLOT)
                begin
                    state_next = S_TICK_END;
                end
                else
                begin
                    cur_next = cur_reg + FIRST_SLOT;
                end
            end

            S_TICK_END:
            begin
                done_next       = 1'b1;
                status_next     = ST_OK;
                last_next       = 1'b1;
                held_valid_next = 1'b0;
                state_next      = S_IDLE;
                if (held_valid_reg)
                begin
                    slot_index_next  = 16'(held_idx_reg);
                    slot_type_next   = held_type_reg;
                    slot_length_next = held_len_reg;
                    retry_next       = held_retry_reg;
                    timed_out_next   = 1'b1;
                end
                else
                begin
                    slot_index_next  = 16'd0;
                    slot_type_next   = 16'd0;
                    slot_length_next = 16'd0;
                    retry_next       = 16'd0;
                    timed_out_next   = 1'b0;
                end
            end

            S_FLUSH:
            begin
                ram_cmd.wr_slot = 1'b1;
                if (cur_reg == LAST_SLOT)
                begin
                    filled_next     = '0;
                    insert_ptr_next = FIRST_SLOT;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + FIRST_SLOT;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cur_reg        <= '0;
            cnt_reg        <= '0;
            insert_ptr_reg <= FIRST_SLOT;
            filled_reg     <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            done_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            cnt_reg        <= cnt_next;
            insert_ptr_reg <= insert_ptr_next;
            filled_reg     <= filled_next;
            done_reg       <= done_next;
            held_valid_reg <= held_valid_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        idx_reg         <= idx_next;
        type_reg        <= type_next;
        len_reg         <= len_next;
        now_reg         <= now_next;
        in_range_reg    <= in_range_next;
        status_reg      <= status_next;
        slot_index_reg  <= slot_index_next;
        slot_type_reg   <= slot_type_next;
        slot_length_reg <= slot_length_next;
        retry_reg       <= retry_next;
        timed_out_reg   <= timed_out_next;
        last_reg        <= last_next;
        held_idx_reg    <= held_idx_next;
        held_type_reg   <= held_type_next;
        held_len_reg    <= held_len_next;
        held_retry_reg  <= held_retry_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign slot_index  = slot_index_reg;
    assign slot_type   = slot_type_reg;
    assign slot_length = slot_length_reg;
    assign retry_count = retry_reg;
    assign timed_out   = timed_out_reg;
    assign last        = last_reg;

    // no result word while the memories are being cleared
    a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !done_reg)
        else $error("result word during clearing pass");

    // a full table reports no slot
    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ST_FULL |-> slot_index_reg == 16'd0)
        else $error("table full word carries a slot index");

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= LAST_SLOT)
        else $error("fill count beyond table size");

    // slot 0 is never handed out
    a_insert_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        insert_ptr_reg != '0)
        else $error("insert pointer at slot 0");

    // idle never writes the memories, so a new command reads settled data
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !(ram_cmd.wr_slot || ram_cmd.wr_retry))
        else $error("memory write while idle");

endmodule
